// ===== hw/rtl/cfr_pkg.sv =====
package cfr_pkg;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_PREAMBLE  = 3'd2;
  localparam logic [2:0] ST_LENGTH    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_POSTAMBLE = 3'd5;
  localparam logic [2:0] ST_CRC       = 3'd6;

  // Frame layout constants.
  localparam logic [7:0]  PREAMBLE_0  = 8'h66;
  localparam logic [7:0]  PREAMBLE_1  = 8'h55;
  localparam logic [7:0]  POSTAMBLE_0 = 8'h77;
  localparam logic [7:0]  POSTAMBLE_1 = 8'h88;
  localparam int unsigned MIN_FRAME   = 13;
  localparam int unsigned PAYLOAD_POS = 9;

  // CRC16-XMODEM constants.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  trans_type;
    logic [7:0]  packet_kind;
    logic [15:0] target_address;
    logic [7:0]  access_kind;
    logic [7:0]  command_code;
    logic [5:0]  payload_length;
    logic [4:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        last;
  } out_t;

  // One byte of CRC16-XMODEM, MSB first.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/cfr_ram.sv =====
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: a write, or a registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/crc_checked_frame_receiver.sv =====
// Frame receiver with CRC16-XMODEM check.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per received
// byte or per idle time tick. Bytes are written into the frame store, one per
// cycle while the input is not stalled; bytes beyond FRAME_BYTES are dropped.
// A tick that brings the idle count to idle_timeout while bytes are held closes
// the frame. On close the block stalls its input and walks the store through its
// single memory port: it scans the n stored bytes, then decides. A failed check
// or an empty payload gives one result beat; a good frame gives one beat per
// payload byte, each read from the store, then loaded into the output register.
// A short frame skips the scan and goes straight to its result; a payload
// holds the input until its last beat is loaded.
// Output channel (out_valid_o / out_stall_i / out_data_o) is an output register;
// while the receiver stalls, the beat holds and the delivery waits for it. Bytes
// and ticks are still taken while a finished result waits.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
// idle_timeout and is always ready; it resets to 10.
// Reset clears the byte count, the idle count and the output valid; the frame
// store contents are not cleared.
module crc_checked_frame_receiver #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cfr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cfr_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned AW = $clog2(FRAME_BYTES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_RESULT  = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_WR = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   idle_q, idle_d;
  logic [15:0]   timeout_q;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] data_idx_q, data_idx_d;
  logic          data_vld_q, data_vld_d;
  logic          pre_bad_q, pre_bad_d;
  logic          len_bad_q, len_bad_d;
  logic          post_bad_q, post_bad_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   rx_crc_q, rx_crc_d;
  logic [7:0]    hdr_q [6];
  logic [7:0]    hdr_d [6];
  logic [CW-1:0] k_q, k_d;
  cfr_pkg::out_t res_q, res_d;
  cfr_pkg::out_t out_q, out_d;
  logic          out_vld_q, out_vld_d;

  logic          in_acc;
  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [CW-1:0] crc_at;
  logic [CW-1:0] plen;
  logic          too_large;

  cfr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_data_i.rx_byte),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Frame geometry derived from the byte count.
  assign crc_at    = count_q - CW'(4);
  assign plen      = count_q - CW'(cfr_pkg::MIN_FRAME);
  assign too_large = 9'(plen) > 9'(MAX_PAYLOAD);

  // Store write on a byte beat, otherwise the walk's read address.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = count_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_we = in_acc && (in_data_i.operation == cfr_pkg::OP_BYTE) &&
                 (9'(count_q) < 9'(FRAME_BYTES));
      end
      S_SCAN:    ram_addr = rd_idx_q[AW-1:0];
      S_EMIT_RD: ram_addr = AW'(k_q + CW'(cfr_pkg::PAYLOAD_POS));
      default:   ram_addr = count_q[AW-1:0];
    endcase
  end

  // Control sequencer: collect, scan, decide, deliver.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idle_d     = idle_q;
    rd_idx_d   = rd_idx_q;
    data_idx_d = data_idx_q;
    data_vld_d = 1'b0;
    pre_bad_d  = pre_bad_q;
    len_bad_d  = len_bad_q;
    post_bad_d = post_bad_q;
    crc_d      = crc_q;
    rx_crc_d   = rx_crc_q;
    hdr_d      = hdr_q;
    k_d        = k_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !(out_vld_q && !out_stall_i);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation == cfr_pkg::OP_BYTE) begin
            idle_d = '0;
            if (9'(count_q) < 9'(FRAME_BYTES)) begin
              count_d = count_q + CW'(1);
            end
          end else begin
            if (idle_q != 16'hFFFF) begin
              idle_d = idle_q + 16'd1;
            end
            if ((count_q != '0) && (idle_d >= timeout_q)) begin
              if (9'(count_q) < 9'(cfr_pkg::MIN_FRAME)) begin
                res_d        = '0;
                res_d.status = cfr_pkg::ST_SHORT;
                res_d.last   = 1'b1;
                state_d      = S_RESULT;
              end else begin
                rd_idx_d   = '0;
                pre_bad_d  = 1'b0;
                len_bad_d  = 1'b0;
                post_bad_d = 1'b0;
                crc_d      = cfr_pkg::CRC_INIT;
                state_d    = S_SCAN;
              end
            end
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous byte is checked.
        if (rd_idx_q < count_q) begin
          rd_idx_d   = rd_idx_q + CW'(1);
          data_idx_d = rd_idx_q;
          data_vld_d = 1'b1;
        end
        if (data_vld_q) begin
          if (data_idx_q == CW'(0)) begin
            pre_bad_d = pre_bad_d || (ram_rdata != cfr_pkg::PREAMBLE_0);
          end
          if (data_idx_q == CW'(1)) begin
            pre_bad_d = pre_bad_d || (ram_rdata != cfr_pkg::PREAMBLE_1);
          end
          if (data_idx_q == CW'(2)) begin
            len_bad_d = (ram_rdata != 8'(count_q));
          end
          for (int h = 0; h < 6; h++) begin
            if (data_idx_q == CW'(h + 3)) begin
              hdr_d[h] = ram_rdata;
            end
          end
          if (data_idx_q < crc_at) begin
            crc_d = cfr_pkg::crc_step(crc_q, ram_rdata);
          end
          if (data_idx_q == crc_at) begin
            rx_crc_d[15:8] = ram_rdata;
          end
          if (data_idx_q == crc_at + CW'(1)) begin
            rx_crc_d[7:0] = ram_rdata;
          end
          if (data_idx_q == crc_at + CW'(2)) begin
            post_bad_d = post_bad_d || (ram_rdata != cfr_pkg::POSTAMBLE_0);
          end
          if (data_idx_q == crc_at + CW'(3)) begin
            post_bad_d = post_bad_d || (ram_rdata != cfr_pkg::POSTAMBLE_1);
            data_vld_d = 1'b0;
            state_d    = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        // Checks in priority order; the earliest failure wins.
        res_d      = '0;
        res_d.last = 1'b1;
        state_d    = S_RESULT;
        if (pre_bad_q) begin
          res_d.status = cfr_pkg::ST_PREAMBLE;
        end else if (len_bad_q) begin
          res_d.status = cfr_pkg::ST_LENGTH;
        end else if (too_large) begin
          res_d.status = cfr_pkg::ST_TOO_LARGE;
        end else if (post_bad_q) begin
          res_d.status = cfr_pkg::ST_POSTAMBLE;
        end else if (crc_q != rx_crc_q) begin
          res_d.status = cfr_pkg::ST_CRC;
        end else begin
          res_d.status         = cfr_pkg::ST_OK;
          res_d.trans_type     = hdr_q[0];
          res_d.packet_kind    = hdr_q[1];
          res_d.target_address = {hdr_q[2], hdr_q[3]};
          res_d.access_kind    = hdr_q[4];
          res_d.command_code   = hdr_q[5];
          res_d.payload_length = 6'(8'(plen));
          if (plen != '0) begin
            res_d.last = 1'b0;
            k_d        = '0;
            state_d    = S_EMIT_RD;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          count_d   = '0;
          state_d   = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        if (out_free) begin
          state_d = S_EMIT_WR;
        end
      end

      S_EMIT_WR: begin
        // The output register is empty here; load this payload byte.
        out_d               = res_q;
        out_d.payload_index = 5'(8'(k_q));
        out_d.payload_byte  = ram_rdata;
        out_d.last          = (k_q + CW'(1) == plen);
        out_vld_d           = 1'b1;
        k_d                 = k_q + CW'(1);
        if (k_q + CW'(1) == plen) begin
          count_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_EMIT_RD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      idle_q     <= '0;
      timeout_q  <= cfr_pkg::TIMEOUT_RESET;
      data_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idle_q     <= idle_d;
      data_vld_q <= data_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    data_idx_q <= data_idx_d;
    pre_bad_q  <= pre_bad_d;
    len_bad_q  <= len_bad_d;
    post_bad_q <= post_bad_d;
    crc_q      <= crc_d;
    rx_crc_q   <= rx_crc_d;
    hdr_q      <= hdr_d;
    k_q        <= k_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

// ===== hw/rtl/cfr_checker.sv =====
module cfr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input cfr_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cfr_pkg::out_t out_data_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Input is held off while a frame still has beats to deliver.
  a_stall_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken in the middle of a frame's results");

  // A failed check is a single beat with no payload.
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != cfr_pkg::ST_OK) |->
      out_data_o.last && (out_data_o.payload_length == 6'd0))
    else $error("error status beat is not a lone final beat");

  // A received byte never produces a result by itself.
  a_byte_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == cfr_pkg::OP_BYTE) &&
      !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a received byte");

endmodule

bind crc_checked_frame_receiver cfr_checker u_cfr_checker (.*);

// ===== sim/crc_checked_frame_receiver_tb.sv =====
module crc_checked_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned MISMATCH_SHOWN = 10;

  typedef logic [7:0] frame_t [$];

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  cfr_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cfr_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [15:0]   cfg_data = '0;

  // Stimulus stream and bookkeeping.
  cfr_pkg::in_t  rx_stream [$];
  cfr_pkg::out_t awaited_reports [$];
  logic        in_taken = 1'b0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned frames_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 76;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  int unsigned status_tally [8];

  // Mirror of the receiver state.
  logic [7:0]  rx_store [FRAME_BYTES];
  int unsigned held_bytes = 0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] timeout_ticks = cfr_pkg::TIMEOUT_RESET;

  crc_checked_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One byte of CRC16-XMODEM, most significant bit first.
  function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] octet);
    logic [15:0] r;
    r = acc ^ {octet, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ cfr_pkg::CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  // Random byte that favors the all-zero and all-one values.
  function automatic logic [7:0] rand_octet();
    case ($urandom_range(7))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return 8'($urandom_range(255));
      end
    endcase
  endfunction

  // Recompute the CRC slot of a frame laid out as a well-formed one.
  function automatic frame_t resealed(frame_t f);
    logic [15:0] crc;
    int unsigned i;
    crc = cfr_pkg::CRC_INIT;
    for (i = 0; i + 4 < f.size(); i++) crc = crc16_byte(crc, f[i]);
    f[f.size() - 4] = crc[15:8];
    f[f.size() - 3] = crc[7:0];
    return f;
  endfunction

  // Well-formed frame with a random header and payload.
  function automatic frame_t make_frame(int unsigned plen);
    frame_t f;
    f = {};
    f.push_back(cfr_pkg::PREAMBLE_0);
    f.push_back(cfr_pkg::PREAMBLE_1);
    f.push_back(8'(cfr_pkg::MIN_FRAME + plen));
    repeat (6 + plen) f.push_back(rand_octet());
    f.push_back(8'h00);
    f.push_back(8'h00);
    f.push_back(cfr_pkg::POSTAMBLE_0);
    f.push_back(cfr_pkg::POSTAMBLE_1);
    return resealed(f);
  endfunction

  // Fill header and payload with one value and reseal.
  function automatic frame_t with_body(frame_t f, logic [7:0] value);
    int unsigned i;
    for (i = 3; i + 4 < f.size(); i++) f[i] = value;
    return resealed(f);
  endfunction

  function automatic void queue_beat(logic op, logic [7:0] value);
    cfr_pkg::in_t b;
    b.operation = op;
    b.rx_byte   = value;
    rx_stream.push_back(b);
    beats_queued++;
  endfunction

  function automatic void queue_ticks(int unsigned count);
    repeat (count) queue_beat(cfr_pkg::OP_TICK, 8'($urandom_range(255)));
  endfunction

  // Queue a frame's bytes, with idle gaps shorter than the timeout, then close it.
  function automatic void send_frame(frame_t f, int unsigned max_gap);
    foreach (f[i]) begin
      queue_beat(cfr_pkg::OP_BYTE, f[i]);
      if (max_gap > 0 && $urandom_range(7) == 0) begin
        queue_ticks($urandom_range(1) ? max_gap : $urandom_range(1, max_gap));
      end
    end
    queue_ticks(int'(timeout_ticks) + $urandom_range(0, 2));
    frames_sent++;
  endfunction

  // Mostly well-formed frames, some damaged ones and some line noise.
  function automatic void send_random_frame();
    frame_t f;
    int unsigned pick;
    int unsigned pos;
    int unsigned plen;
    int unsigned noise_len;
    pick = $urandom_range(99);
    plen = ($urandom_range(7) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(6);
    f = make_frame(plen);
    if (pick >= 65 && pick < 85) begin
      case ($urandom_range(3))
        0: begin
          pos = $urandom_range(f.size() - 1);
          f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
        end
        1: begin
          void'(f.pop_back());
        end
        2: begin
          f.push_back(rand_octet());
        end
        default: begin
          f[2] = rand_octet();
        end
      endcase
    end else if (pick >= 85) begin
      f = {};
      if ($urandom_range(3) == 0) begin
        f.push_back(cfr_pkg::PREAMBLE_0);
        f.push_back(cfr_pkg::PREAMBLE_1);
      end
      noise_len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
      repeat (noise_len) f.push_back(rand_octet());
    end
    send_frame(f, int'(timeout_ticks) - 1);
  endfunction

  function automatic void run_random(int unsigned beats, int unsigned frames);
    int unsigned first_beat;
    int unsigned first_frame;
    first_beat  = beats_queued;
    first_frame = frames_sent;
    while (beats_queued - first_beat < beats || frames_sent - first_frame < frames) begin
      if ($urandom_range(9) == 0) queue_ticks($urandom_range(1, 20));
      send_random_frame();
    end
  endfunction

  // Check a closed frame and queue the report beats it yields.
  function automatic void judge_frame();
    cfr_pkg::out_t rep;
    logic [2:0]    verdict;
    logic [15:0]   crc;
    int unsigned   n;
    int unsigned   plen;
    int unsigned   i;
    n    = held_bytes;
    plen = (n > cfr_pkg::MIN_FRAME) ? n - cfr_pkg::MIN_FRAME : 0;
    crc  = cfr_pkg::CRC_INIT;
    if (n < cfr_pkg::MIN_FRAME) begin
      verdict = cfr_pkg::ST_SHORT;
    end else if (rx_store[0] != cfr_pkg::PREAMBLE_0 || rx_store[1] != cfr_pkg::PREAMBLE_1) begin
      verdict = cfr_pkg::ST_PREAMBLE;
    end else if (rx_store[2] != n) begin
      verdict = cfr_pkg::ST_LENGTH;
    end else if (plen > MAX_PAYLOAD) begin
      verdict = cfr_pkg::ST_TOO_LARGE;
    end else if (rx_store[n - 2] != cfr_pkg::POSTAMBLE_0 ||
                 rx_store[n - 1] != cfr_pkg::POSTAMBLE_1) begin
      verdict = cfr_pkg::ST_POSTAMBLE;
    end else begin
      for (i = 0; i < n - 4; i++) crc = crc16_byte(crc, rx_store[i]);
      verdict = (crc == {rx_store[n - 4], rx_store[n - 3]}) ? cfr_pkg::ST_OK : cfr_pkg::ST_CRC;
    end
    status_tally[verdict]++;

    rep        = '0;
    rep.status = verdict;
    rep.last   = 1'b1;
    if (verdict != cfr_pkg::ST_OK) begin
      awaited_reports.push_back(rep);
    end else begin
      rep.trans_type     = rx_store[3];
      rep.packet_kind    = rx_store[4];
      rep.target_address = {rx_store[5], rx_store[6]};
      rep.access_kind    = rx_store[7];
      rep.command_code   = rx_store[8];
      rep.payload_length = 6'(plen);
      // An empty payload still reports the header once.
      if (plen == 0) awaited_reports.push_back(rep);
      for (i = 0; i < plen; i++) begin
        rep.payload_index = 5'(i);
        rep.payload_byte  = rx_store[cfr_pkg::PAYLOAD_POS + i];
        rep.last          = (i + 1 == plen);
        awaited_reports.push_back(rep);
      end
    end
  endfunction

  // Apply one accepted input beat to the mirrored state.
  function automatic void absorb_beat(cfr_pkg::in_t b);
    if (b.operation == cfr_pkg::OP_BYTE) begin
      // Bytes past the end of the store are dropped but still reset the idle count.
      if (held_bytes < FRAME_BYTES) begin
        rx_store[held_bytes] = b.rx_byte;
        held_bytes++;
      end
      idle_ticks = '0;
    end else begin
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      if (held_bytes > 0 && idle_ticks >= timeout_ticks) begin
        judge_frame();
        held_bytes = 0;
      end
    end
  endfunction

  function automatic string describe(cfr_pkg::out_t r);
    return {$sformatf("st=%0d tt=%02h pk=%02h addr=%04h acc=%02h ", r.status,
                      r.trans_type, r.packet_kind, r.target_address, r.access_kind),
            $sformatf("cmd=%02h len=%0d idx=%0d pb=%02h last=%0d", r.command_code,
                      r.payload_length, r.payload_index, r.payload_byte, r.last)};
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MISMATCH_SHOWN) $display("ERROR: %s", msg);
  endfunction

  function automatic void check_report(cfr_pkg::out_t got);
    cfr_pkg::out_t want;
    string         bad;
    reports_seen++;
    if (awaited_reports.size() == 0) begin
      note_failure($sformatf("result beat with none pending: %s", describe(got)));
      return;
    end
    want = awaited_reports.pop_front();
    bad  = "";
    if (got.status !== want.status) bad = {bad, " status"};
    if (got.trans_type !== want.trans_type) bad = {bad, " trans_type"};
    if (got.packet_kind !== want.packet_kind) bad = {bad, " packet_kind"};
    if (got.target_address !== want.target_address) bad = {bad, " target_address"};
    if (got.access_kind !== want.access_kind) bad = {bad, " access_kind"};
    if (got.command_code !== want.command_code) bad = {bad, " command_code"};
    if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
    if (got.payload_index !== want.payload_index) bad = {bad, " payload_index"};
    if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (bad != "") begin
      note_failure($sformatf("wrong%s: expected %s, actual %s", bad, describe(want),
                             describe(got)));
    end
  endfunction

  // Input driver: a new beat may go out once the previous one was taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random idling plus the long hold-off when one is running.
  always @(negedge clk_i) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Hold-off counter.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: mirror each accepted input beat, then check each accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        absorb_beat(in_data);
        beats_taken++;
      end
      if (out_valid && !out_stall) check_report(out_data);
    end
    in_taken <= rst_ni && in_valid && !in_stall;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats still queued.", cycle_count,
               beats_queued - beats_taken);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Wait for every beat to be taken and every result to arrive, then let the block go quiet.
  task automatic settle();
    while (beats_taken != beats_queued || awaited_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    timeout_ticks = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    frame_t f;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timeout of ten ticks: an empty payload and a single stray byte.
    queue_ticks(3);
    send_frame(with_body(make_frame(0), 8'hFF), 0);
    f = make_frame(2);
    send_frame(f[0:0], 0);
    settle();

    // Timeout of one tick: the first tick closes the frame. One frame per failed check.
    write_timeout(16'd1);
    send_frame(f[0:11], 0);
    f = make_frame(2);
    f[0] = f[0] ^ 8'h01;
    send_frame(f, 0);
    f = make_frame(3);
    f[2] = f[2] + 8'd1;
    send_frame(f, 0);
    f = make_frame(1);
    f[f.size() - 1] = 8'h87;
    send_frame(f, 0);
    f = make_frame(5);
    f[cfr_pkg::PAYLOAD_POS] = f[cfr_pkg::PAYLOAD_POS] ^ 8'h01;
    send_frame(f, 0);
    // Overfill the store: the extra bytes are dropped and the frame is too large.
    f = make_frame(FRAME_BYTES - cfr_pkg::MIN_FRAME);
    repeat (6) f.push_back(rand_octet());
    send_frame(f, 0);
    run_random(20, 1);
    settle();

    // Slow sender, mostly ready receiver.
    send_idle_pct = 76;
    recv_idle_pct = 15;
    write_timeout(16'd5);
    run_random(20, 1);
    settle();

    // No idling; a long output hold-off fills the block while bytes keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(16'd2);
    @(negedge clk_i);
    hold_go <= 1'b1;
    @(negedge clk_i);
    hold_go <= 1'b0;
    @(posedge clk_i);
    send_frame(with_body(make_frame(MAX_PAYLOAD), 8'h00), 1);
    send_frame(make_frame(4), 0);
    settle();

    if (awaited_reports.size() != 0) begin
      note_failure($sformatf("%0d result beats never arrived", awaited_reports.size()));
    end
    $display("Run covered %0d input beats in %0d frames and %0d result beats,",
             beats_taken, frames_sent, reports_seen);
    $display("timeouts 1 to 10, every status: ok %0d, short %0d, preamble %0d, length %0d,",
             status_tally[cfr_pkg::ST_OK], status_tally[cfr_pkg::ST_SHORT],
             status_tally[cfr_pkg::ST_PREAMBLE], status_tally[cfr_pkg::ST_LENGTH]);
    $display("too large %0d, postamble %0d, crc %0d; %0d mismatches.",
             status_tally[cfr_pkg::ST_TOO_LARGE], status_tally[cfr_pkg::ST_POSTAMBLE],
             status_tally[cfr_pkg::ST_CRC], mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
